/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Overlapping implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

/* hdl/bsst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsst_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int DATA_W      = 32;
   localparam int CFG_W       = 5;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } state_type;

   typedef struct packed {
      logic tbl_wr;
      logic start;
      logic step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/bsst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsst_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_cmd,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire bsst_pkg::dp_status_type sts,
   output bsst_pkg::ctrl_cmd_type      cmd
);
   import bsst_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.tbl_wr   = 1'b0;
      cmd.start    = 1'b0;
      cmd.step     = 1'b0;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_WRITE) begin
               cmd.tbl_wr = 1'b1;
            end
            if (accept && req_cmd == CMD_SEARCH) begin
               cmd.start = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!sts.done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/bsst_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsst_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bsst_pkg::CFG_W-1:0]          csr_wr_data,
   input  wire logic [bsst_pkg::IDX_W-1:0]          req_entry_index,
   input  wire logic signed [bsst_pkg::DATA_W-1:0]  req_data_value,
   input  wire bsst_pkg::ctrl_cmd_type              cmd,
   output bsst_pkg::dp_status_type                  sts,
   output logic                                     rsp_found,
   output logic [bsst_pkg::IDX_W-1:0]               rsp_position
);
   import bsst_pkg::*;

   logic signed [DATA_W-1:0] table_ff [TABLE_DEPTH];
   logic [CFG_W-1:0]         count_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic [CNT_W-1:0]         low_ff, low_in;
   logic [CNT_W-1:0]         end_ff, end_in;
   logic                     found_ff;
   logic [IDX_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] entry_ff;

   logic [CNT_W-1:0]         count_sat;
   logic [SUM_W-1:0]         mid_sum;
   logic [IDX_W-1:0]         mid;
   logic [SUM_W-1:0]         mid_sum_in;
   logic [IDX_W-1:0]         mid_in;
   logic [CNT_W-1:0]         mid_ext;
   logic [CNT_W-1:0]         mid_plus1;
   logic                     empty_now;
   logic                     hit;
   logic                     key_lt;
   logic                     next_empty;

   // high is held as end = high + 1 so both bounds stay unsigned
   assign count_sat = (count_ff > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(count_ff);
   assign mid_sum   = SUM_W'(low_ff) + SUM_W'(end_ff) - SUM_W'(1);
   assign mid       = mid_sum[IDX_W:1];
   assign mid_ext   = CNT_W'(mid);
   assign mid_plus1 = mid_ext + CNT_W'(1);

   // probe address for the next cycle, so the entry comes out of a register
   assign mid_sum_in = SUM_W'(low_in) + SUM_W'(end_in) - SUM_W'(1);
   assign mid_in     = mid_sum_in[IDX_W:1];

   assign empty_now  = (low_ff >= end_ff);
   assign hit        = !empty_now && (entry_ff == key_ff);
   assign key_lt     = (key_ff < entry_ff);
   assign next_empty = key_lt ? (low_ff >= mid_ext) : (mid_plus1 >= end_ff);
   assign sts.done   = empty_now || hit || next_empty;

   always_comb begin
      low_in = low_ff;
      end_in = end_ff;
      if (cmd.start) begin
         low_in = '0;
         end_in = count_sat;
      end else if (cmd.step) begin
         if (key_lt) begin
            end_in = mid_ext;
         end else begin
            low_in = mid_plus1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) begin
         table_ff[req_entry_index] <= req_data_value;
      end
      entry_ff <= table_ff[mid_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_data_value;
      end
      low_ff <= low_in;
      end_ff <= end_in;
      if (cmd.load_rsp) begin
         found_ff <= hit;
         pos_ff   <= hit ? mid : '0;
      end
   end

   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;

endmodule

`default_nettype wire

/* hdl/binary_search_sorted_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Sorted-table lookup. Holds 16 signed 32-bit entries, written one item at a
// time (req_cmd = 0) and searched by binary search over the first
// csr_wr_data-programmed element count entries (req_cmd = 1; counts above 16
// act as 16). A write item leaves the unit idle and gives no result. A search
// item probes one entry per cycle through its compare logic: up to 5
// probes (an empty count still enters the search state), and the input is busy
// while the probe loop runs over the register-file table and while the
// finished search waits for the output register to empty.
// The result sits in an output register, so the next item may be taken while
// a result waits on rsp_ready.
// Entries must be written before a search can reach them.

module binary_search_sorted_table_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bsst_pkg::CFG_W-1:0]          csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_cmd,
   input  wire logic [bsst_pkg::IDX_W-1:0]          req_entry_index,
   input  wire logic signed [bsst_pkg::DATA_W-1:0]  req_data_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_found,
   output logic [bsst_pkg::IDX_W-1:0]               rsp_position
);
   import bsst_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   bsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsst_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_entry_index (req_entry_index),
      .req_data_value  (req_data_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

   `ASSERT_IMPLIES(a_miss_pos_zero, clock, reset, rsp_valid && !rsp_found, rsp_position == '0)
   `ASSERT_NEXT(a_write_no_rsp, clock, reset, req_valid && req_ready && req_cmd == CMD_WRITE && !rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_search_busy, clock, reset, req_valid && req_ready && req_cmd == CMD_SEARCH, !req_ready)
   `ASSERT_ALWAYS(a_one_step, clock, reset, !(cmd.step && cmd.load_rsp))

endmodule

`default_nettype wire

/* tb/binary_search_sorted_table_unit_tb.sv */
`timescale 1ns / 1ps

module binary_search_sorted_table_unit_tb;
   import bsst_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_REPORTED = 10;
   localparam int CSR_SETTLE   = 8;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
   } lookup_type;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     csr_wr_en       = 1'b0;
   logic [CFG_W-1:0]         csr_wr_data     = '0;
   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic                     req_cmd         = CMD_WRITE;
   logic [IDX_W-1:0]         req_entry_index = '0;
   logic signed [DATA_W-1:0] req_data_value  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready       = 1'b0;
   logic                     rsp_found;
   logic [IDX_W-1:0]         rsp_position;

   // local copy of the block's state
   logic signed [DATA_W-1:0] tbl_model [TABLE_DEPTH];
   logic [CFG_W-1:0]         cnt_model = '0;

   lookup_type expected_lookups [$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int rsp_hold_left  = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int searches_sent  = 0;
   int writes_sent    = 0;
   int hits_seen      = 0;
   int count_writes   = 0;

   binary_search_sorted_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_data_value  (req_data_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_lookups.size());
         $display("binary_search_sorted_table_unit_tb: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic lookup_type predict_lookup(logic signed [DATA_W-1:0] key);
      lookup_type res;
      int         lo;
      int         hi;
      int         mid;
      res = '0;
      lo  = 0;
      hi  = ((cnt_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt_model)) - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (tbl_model[mid] == key) begin
            res.found    = 1'b1;
            res.position = IDX_W'(mid);
            return res;
         end
         if (key < tbl_model[mid]) hi = mid - 1;
         else lo = mid + 1;
      end
      return res;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_key();
      int                       n;
      logic signed [DATA_W-1:0] k;
      n = (cnt_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt_model);
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: k = (n > 0) ? tbl_model[$urandom_range(n - 1)] : $urandom;
         6, 7: k = tbl_model[$urandom_range(TABLE_DEPTH - 1)] + ($urandom_range(1) ? 1 : -1);
         default: k = $urandom;
      endcase
      return k;
   endfunction

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) $display("ERROR @%0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin : check_results
      lookup_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lookups.size() == 0) begin
            report_error($sformatf("unexpected result found=%0b position=%0d",
                                   rsp_found, rsp_position));
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_found !== want.found || rsp_position !== want.position)
               report_error($sformatf("expected found=%0b position=%0d, got found=%0b position=%0d",
                                      want.found, want.position, rsp_found, rsp_position));
            else if (want.found)
               hits_seen++;
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_entry_index <= idx;
      req_data_value  <= val;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_WRITE) begin
         tbl_model[idx] = val;
         writes_sent++;
      end else begin
         expected_lookups.push_back(predict_lookup(val));
         searches_sent++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_lookups.size() != 0);
   endtask

   task automatic set_count(input logic [CFG_W-1:0] n);
      wait_drained();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cnt_model = n;
      count_writes++;
   endtask

   task automatic search(input logic signed [DATA_W-1:0] key);
      send_item(CMD_SEARCH, IDX_W'($urandom), key);
   endtask

   // wide: full-range sorted; narrow: small sorted values with duplicates;
   // otherwise unsorted random
   task automatic fill_table(input int mode);
      logic signed [DATA_W-1:0] vals [TABLE_DEPTH];
      logic signed [DATA_W-1:0] v;
      int                       j;
      for (int i = 0; i < TABLE_DEPTH; i++)
         vals[i] = (mode == 1) ? int'($urandom_range(40)) - 20 : $urandom;
      if (mode < 2) begin
         for (int i = 1; i < TABLE_DEPTH; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > v) begin
               vals[j] = vals[j-1];
               j--;
            end
            vals[j] = v;
         end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) send_item(CMD_WRITE, IDX_W'(i), vals[i]);
   endtask

   task automatic test_directed();
      logic signed [DATA_W-1:0] seed_vals [TABLE_DEPTH];
      seed_vals = '{32'sh8000_0000, -1000000, -65536, -300, -2, -1, 0, 1,
                    2, 7, 100, 4096, 65535, 1000000, 32'sh7fff_fffe, 32'sh7fff_ffff};
      // empty table after reset
      search(0);
      search(32'sh7fff_ffff);
      search(32'sh8000_0000);
      for (int i = 0; i < TABLE_DEPTH; i++) send_item(CMD_WRITE, IDX_W'(i), seed_vals[i]);
      set_count(16);
      search(32'sh8000_0000);
      search(32'sh7fff_ffff);
      search(0);
      search(3);
      // counts above the table size saturate
      set_count(31);
      search(32'sh7fff_ffff);
      set_count(1);
      search(32'sh8000_0000);
      search(-1);
   endtask

   task automatic test_count_sweep();
      logic [CFG_W-1:0] counts [8];
      counts = '{0, 1, 2, 3, 15, 16, 17, 31};
      foreach (counts[k]) begin
         set_count(counts[k]);
         repeat (16) search(pick_key());
      end
   endtask

   task automatic test_unsorted_table();
      fill_table(2);
      set_count(16);
      repeat (60) search(pick_key());
   endtask

   task automatic test_backpressure();
      set_count(16);
      send_idle_pct = 0;
      stall_pct     = 0;
      rsp_hold_left <= 300;
      repeat (24) search(pick_key());
      wait_drained();
      repeat (16) search(pick_key());
      wait_drained();
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (4) begin
         fill_table($urandom_range(1));
         set_count($urandom_range(9) < 6 ? CFG_W'(16) : CFG_W'($urandom_range(31)));
         repeat (40) begin
            if ($urandom_range(19) == 0) send_item(CMD_WRITE, IDX_W'($urandom), $urandom);
            else search(pick_key());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_count_sweep();
      test_unsorted_table();
      test_random_phase(0, 0);
      test_random_phase(88, 0);
      test_random_phase(0, 88);
      test_random_phase(9, 9);
      test_backpressure();
      wait_drained();
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (20) @(posedge clock);
      $display("covered %0d searches (%0d hits), %0d table writes, %0d count settings",
               searches_sent, hits_seen, writes_sent, count_writes);
      $display("sorted, duplicate and unsorted tables; empty and saturated counts; %0d errors",
               mismatch_count);
      if (mismatch_count == 0 && expected_lookups.size() == 0) begin
         $display("binary_search_sorted_table_unit_tb: done, clean");
      end else begin
         $display("binary_search_sorted_table_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

/* binary_search_sorted_table_unit.f */
+incdir+hdl
hdl/bsst_pkg.sv
hdl/bsst_ctrl.sv
hdl/bsst_dp.sv
hdl/binary_search_sorted_table_unit.sv
tb/binary_search_sorted_table_unit_tb.sv
